@@ design/chained_hash_table_top_assert.svh @@
// Assertion macros for the chained hash table checker.
// Depends on nothing; included by the checker file only.
`ifndef CHAINED_HASH_TABLE_TOP_ASSERT_SVH
`define CHAINED_HASH_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held low.
`define CHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low.
`define CHT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cht_pkg.sv @@
// Shared types, field widths, operation and status codes for the chained hash table.
// No dependencies; compile first.
package cht_pkg;

    localparam int KEY_W    = 31;
    localparam int VAL_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int BIDX_W   = 4;

    localparam int DEF_NUM_BUCKETS = 16;
    localparam int DEF_CHAIN_DEPTH = 4;

    typedef logic [KEY_W-1:0]        t_key;
    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [FUNC_W-1:0]       t_func;
    typedef logic [STATUS_W-1:0]     t_status;
    typedef logic [BIDX_W-1:0]       t_bidx;

    localparam t_func FN_INSERT = 2'd0;
    localparam t_func FN_SEARCH = 2'd1;
    localparam t_func FN_DELETE = 2'd2;

    localparam t_status ST_INSERTED  = 3'd0;
    localparam t_status ST_COLLISION = 3'd1;
    localparam t_status ST_FOUND     = 3'd2;
    localparam t_status ST_NOT_FOUND = 3'd3;
    localparam t_status ST_DELETED   = 3'd4;
    localparam t_status ST_DEL_MISS  = 3'd5;
    localparam t_status ST_FULL      = 3'd6;

endpackage

@@ design/cht_if.sv @@
// Request and response channel interfaces (valid/ready) of the chained hash table.
// Depends on cht_pkg.
interface cht_req_if;
    import cht_pkg::*;

    logic   valid;
    logic   ready;
    t_func  func;
    t_key   key;
    t_value value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface cht_rsp_if;
    import cht_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_bidx   bucket_index;
    t_value  found_value;

    modport source (output valid, output status, output bucket_index, output found_value,
                    input ready);
    modport sink   (input valid, input status, input bucket_index, input found_value,
                    output ready);
endinterface

@@ design/cht_mod_unit.sv @@
// Remainder unit: key modulo NUM_BUCKETS by reciprocal multiplication, quotient then remainder registered.
// Depends on cht_pkg.
module cht_mod_unit #(
    parameter int NUM_BUCKETS = cht_pkg::DEF_NUM_BUCKETS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  cht_pkg::t_key                  i_key,
    output logic                           o_done,
    output logic [$clog2(NUM_BUCKETS)-1:0] o_rem
);
    import cht_pkg::*;

    localparam int BKT_W   = $clog2(NUM_BUCKETS);
    localparam int RECIP_W = KEY_W + 1;
    localparam int PROD_W  = KEY_W + RECIP_W;
    localparam int SHIFT   = KEY_W + BKT_W;
    // ceil(2^SHIFT / NUM_BUCKETS) gives an exact quotient for every key
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(NUM_BUCKETS - 1)) / 64'(NUM_BUCKETS);
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_WIDE);
    localparam logic [BKT_W-1:0]   DIV_LO = BKT_W'(NUM_BUCKETS);

    logic               r_s1;
    logic               r_done;
    logic [BKT_W-1:0]   r_quo_lo;
    logic [BKT_W-1:0]   r_key_lo;
    logic [BKT_W-1:0]   r_rem;

    logic [PROD_W-1:0]  prod;
    logic [2*BKT_W-1:0] back_prod;
    logic [BKT_W-1:0]   n_rem;

    // The remainder is below the bucket count, so only the low bits need the back-multiply
    assign prod      = i_key * RECIP;
    assign back_prod = r_quo_lo * DIV_LO;
    assign n_rem     = r_key_lo - back_prod[BKT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start;
            r_done <= r_s1;
            if (i_start) begin
                r_quo_lo <= prod[SHIFT +: BKT_W];
                r_key_lo <= i_key[BKT_W-1:0];
            end
            if (r_s1) begin
                r_rem <= n_rem;
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ design/cht_row_edit.sv @@
// Row rewrite for one bucket: push a new entry at the head, or remove one slot
// and close the gap. Depends on cht_pkg.
module cht_row_edit #(
    parameter int CHAIN_DEPTH = cht_pkg::DEF_CHAIN_DEPTH
) (
    input  logic                                      i_insert,
    input  logic [((CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1)-1:0] i_slot,
    input  cht_pkg::t_key                             i_key,
    input  cht_pkg::t_value                           i_value,
    input  cht_pkg::t_key   [CHAIN_DEPTH-1:0]         i_keys,
    input  cht_pkg::t_value [CHAIN_DEPTH-1:0]         i_vals,
    input  logic [$clog2(CHAIN_DEPTH+1)-1:0]          i_len,
    output cht_pkg::t_key   [CHAIN_DEPTH-1:0]         o_keys,
    output cht_pkg::t_value [CHAIN_DEPTH-1:0]         o_vals,
    output logic [$clog2(CHAIN_DEPTH+1)-1:0]          o_len
);
    import cht_pkg::*;

    localparam int LEN_W  = $clog2(CHAIN_DEPTH + 1);
    localparam int SLOT_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;

    t_key   [CHAIN_DEPTH-1:0] ins_keys;
    t_value [CHAIN_DEPTH-1:0] ins_vals;
    t_key   [CHAIN_DEPTH-1:0] del_keys;
    t_value [CHAIN_DEPTH-1:0] del_vals;

    for (genvar g = 0; g < CHAIN_DEPTH; g++) begin : g_slot
        if (g == 0) begin : g_head
            assign ins_keys[g] = i_key;
            assign ins_vals[g] = i_value;
        end else begin : g_push
            assign ins_keys[g] = i_keys[g-1];
            assign ins_vals[g] = i_vals[g-1];
        end

        // Slots at or after the removed one pull up from their neighbour
        if (g < CHAIN_DEPTH - 1) begin : g_pull
            assign del_keys[g] = (SLOT_W'(g) >= i_slot) ? i_keys[g+1] : i_keys[g];
            assign del_vals[g] = (SLOT_W'(g) >= i_slot) ? i_vals[g+1] : i_vals[g];
        end else begin : g_tail
            assign del_keys[g] = i_keys[g];
            assign del_vals[g] = i_vals[g];
        end
    end

    assign o_keys = i_insert ? ins_keys : del_keys;
    assign o_vals = i_insert ? ins_vals : del_vals;
    assign o_len  = i_insert ? (i_len + LEN_W'(1)) : (i_len - LEN_W'(1));

endmodule

@@ design/chained_hash_table_top.sv @@
// Chained hash table: NUM_BUCKETS buckets of up to CHAIN_DEPTH key/value entries each.
// Insert: the row is read (S_READ), then written back with the result (S_WB); ready again in S_IDLE.
// Search/delete: S_SCAN walks the row from the head to a match or the chain length, then S_WB.
// A bucket count that is not a power of two adds S_MOD, which waits for the remainder unit.
// After reset a clearing pass (S_CLEAR) zeroes the chain length of every bucket; not ready meanwhile.
// Depends on cht_pkg, cht_if, cht_mod_unit and cht_row_edit.
module chained_hash_table_top #(
    parameter int NUM_BUCKETS = cht_pkg::DEF_NUM_BUCKETS,
    parameter int CHAIN_DEPTH = cht_pkg::DEF_CHAIN_DEPTH
) (
    input logic       i_clk,
    input logic       i_rst_n,
    cht_req_if.sink   i_req,
    cht_rsp_if.source o_rsp
);
    import cht_pkg::*;

    localparam int BKT_W   = $clog2(NUM_BUCKETS);
    localparam int LEN_W   = $clog2(CHAIN_DEPTH + 1);
    localparam int SLOT_W  = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam bit IS_POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_SCAN,
        S_WB
    } t_state;

    // Bucket rows: all slots of one bucket sit at one address
    t_key   [CHAIN_DEPTH-1:0] mem_keys [NUM_BUCKETS];
    t_value [CHAIN_DEPTH-1:0] mem_vals [NUM_BUCKETS];
    logic   [LEN_W-1:0]       mem_len  [NUM_BUCKETS];

    t_state                   r_state;
    logic [BKT_W-1:0]         r_clr;
    t_func                    r_func;
    t_key                     r_key;
    t_value                   r_value;
    logic [BKT_W-1:0]         r_bucket;
    t_key   [CHAIN_DEPTH-1:0] r_row_keys;
    t_value [CHAIN_DEPTH-1:0] r_row_vals;
    logic [LEN_W-1:0]         r_row_len;
    logic [LEN_W-1:0]         r_slot;
    logic                     r_hit;
    logic                     r_out_valid;
    t_status                  r_status;
    t_bidx                    r_bidx;
    t_value                   r_fval;

    logic                     req_acc;
    logic                     commit;
    logic                     slot_match;
    logic                     mod_done;
    logic [BKT_W-1:0]         mod_rem;
    t_key   [CHAIN_DEPTH-1:0] ed_keys;
    t_value [CHAIN_DEPTH-1:0] ed_vals;
    logic [LEN_W-1:0]         ed_len;
    logic                     wb_write;
    t_status                  wb_status;
    t_value                   wb_fval;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && (r_state == S_IDLE);
    // Write back and load the result only once the output register is free
    assign commit      = (r_state == S_WB) && (!r_out_valid || o_rsp.ready);
    assign slot_match  = (r_row_keys[r_slot[SLOT_W-1:0]] == r_key);

    cht_mod_unit #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (req_acc && !IS_POW2),
        .i_key   (i_req.key),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    cht_row_edit #(
        .CHAIN_DEPTH (CHAIN_DEPTH)
    ) u_edit (
        .i_insert (r_func == FN_INSERT),
        .i_slot   (r_slot[SLOT_W-1:0]),
        .i_key    (r_key),
        .i_value  (r_value),
        .i_keys   (r_row_keys),
        .i_vals   (r_row_vals),
        .i_len    (r_row_len),
        .o_keys   (ed_keys),
        .o_vals   (ed_vals),
        .o_len    (ed_len)
    );

    always_comb begin
        wb_write  = 1'b0;
        wb_status = ST_NOT_FOUND;
        wb_fval   = '0;
        case (r_func)
            FN_INSERT: begin
                if (r_row_len == LEN_W'(CHAIN_DEPTH)) begin
                    wb_status = ST_FULL;
                end else begin
                    wb_write  = 1'b1;
                    wb_status = (r_row_len == '0) ? ST_INSERTED : ST_COLLISION;
                end
            end
            FN_DELETE: begin
                if (r_hit) begin
                    wb_write  = 1'b1;
                    wb_status = ST_DELETED;
                end else begin
                    wb_status = ST_DEL_MISS;
                end
            end
            default: begin
                // search, and the unused code acts as one
                if (r_hit) begin
                    wb_status = ST_FOUND;
                    wb_fval   = r_row_vals[r_slot[SLOT_W-1:0]];
                end else begin
                    wb_status = ST_NOT_FOUND;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem_len[r_clr] <= '0;
        end else if (commit && wb_write) begin
            mem_len[r_bucket]  <= ed_len;
            mem_keys[r_bucket] <= ed_keys;
            mem_vals[r_bucket] <= ed_vals;
        end
        if (r_state == S_READ) begin
            r_row_keys <= mem_keys[r_bucket];
            r_row_vals <= mem_vals[r_bucket];
            r_row_len  <= mem_len[r_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BKT_W'(1);
                    if (r_clr == BKT_W'(NUM_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func   <= i_req.func;
                        r_key    <= i_req.key;
                        r_value  <= i_req.value;
                        r_bucket <= i_req.key[BKT_W-1:0];
                        r_state  <= IS_POW2 ? S_READ : S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_bucket <= mod_rem;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_slot  <= '0;
                    r_state <= (r_func == FN_INSERT) ? S_WB : S_SCAN;
                end
                S_SCAN: begin
                    // walk from the head, one slot compare per cycle
                    if (r_slot == r_row_len) begin
                        r_hit   <= 1'b0;
                        r_state <= S_WB;
                    end else if (slot_match) begin
                        r_hit   <= 1'b1;
                        r_state <= S_WB;
                    end else begin
                        r_slot <= r_slot + LEN_W'(1);
                    end
                end
                S_WB: begin
                    if (commit) begin
                        r_out_valid <= 1'b1;
                        r_status    <= wb_status;
                        r_bidx      <= BIDX_W'(r_bucket);
                        r_fval      <= wb_fval;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.bucket_index = r_bidx;
    assign o_rsp.found_value  = r_fval;

endmodule

@@ design/cht_checker.sv @@
// Port-level checker for the chained hash table, bound to the top level.
// Depends on cht_pkg and chained_hash_table_top_assert.svh.
`include "chained_hash_table_top_assert.svh"

module cht_port_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input cht_pkg::t_status i_rsp_status,
    input cht_pkg::t_value  i_rsp_fval
);
    import cht_pkg::*;

    `CHT_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready,
        i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_fval), "stalled response changed")
    `CHT_ASSERT_IMP(a_fval_zero, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status != ST_FOUND),
        i_rsp_fval == '0, "value returned without a hit")
    `CHT_ASSERT_NXT(a_busy_after_acc, i_clk, i_rst_n, i_req_valid && i_req_ready,
        !i_req_ready, "ready held after acceptance")
    `CHT_ASSERT_IMP(a_rsp_from_work, i_clk, i_rst_n, $rose(i_rsp_valid),
        !$past(i_req_ready), "response without a transaction in flight")

endmodule

bind chained_hash_table_top cht_port_checker u_cht_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_fval   (o_rsp.found_value)
);
